FILE: src/ilpf_pkg.sv
// Shared constants and types for the integer lowpass filter.
package ilpf_pkg;

    localparam int TAP_SPACING = 10;
    localparam int FRAME_LEN   = 500;
    localparam int DELAY_DEPTH = 2 * TAP_SPACING;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;
    localparam int INDEX_W  = $clog2(FRAME_LEN);
    localparam int FILL_W   = $clog2(TAP_SPACING + 1);

    // Division by M*M is a multiplication by a rounded-up reciprocal.
    localparam int DIVISOR     = TAP_SPACING * TAP_SPACING;
    localparam int DIV_LOG     = $clog2(DIVISOR);
    localparam int RECIP_SHIFT = ACC_W + DIV_LOG;
    localparam int RECIP_W     = ACC_W + 1;
    localparam int PROD_W      = RECIP_W + ACC_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'(32767);
    localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(32768);
    localparam logic [SAMPLE_W-1:0] POS_SAT = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] NEG_SAT = 16'h8000;

    // One result on its way to the scaler: magnitude of y, its sign, end mark.
    typedef struct packed {
        logic [ACC_W-1:0] mag;
        logic             neg;
        logic             frame_end;
    } ilpf_item_t;

endpackage

FILE: src/ilpf_if.sv
// Valid/ready channel interfaces for samples and filtered results.
interface ilpf_in_if;
    import ilpf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

interface ilpf_out_if;
    import ilpf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered_value;
    logic                       frame_end;

    modport source (output valid, output filtered_value, output frame_end, input ready);
    modport sink (input valid, input filtered_value, input frame_end, output ready);
endinterface

FILE: src/ilpf_tap.sv
// One cell of the sample delay line.
module ilpf_tap
    import ilpf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  logic                       clear,
    input  logic signed [SAMPLE_W-1:0] din,
    output logic signed [SAMPLE_W-1:0] dout
);

    logic signed [SAMPLE_W-1:0] data_reg;
    logic signed [SAMPLE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = clear ? '0 : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

FILE: src/ilpf_scale.sv
// Divides by M*M through a reciprocal multiply, saturates, holds the result.
module ilpf_scale
    import ilpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  ilpf_item_t         item,
    output logic               item_ready,
    ilpf_out_if.source         results
);

    logic                       prod_valid_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       prod_neg_reg;
    logic                       prod_end_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic                       out_end_reg;

    logic                       out_load;
    logic                       prod_load;
    logic [PROD_W-1:0]          quot;
    logic [SAMPLE_W-1:0]        value_next;

    assign out_load   = !out_valid_reg || results.ready;
    assign prod_load  = !prod_valid_reg || out_load;
    assign item_ready = prod_load;

    always_comb
    begin
        quot = prod_reg >> RECIP_SHIFT;
        if (prod_neg_reg)
        begin
            value_next = (quot > NEG_LIMIT) ? NEG_SAT : SAMPLE_W'(~quot[SAMPLE_W-1:0] + 1'b1);
        end
        else
        begin
            value_next = (quot > POS_LIMIT) ? POS_SAT : quot[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_load)
            begin
                prod_valid_reg <= item_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_load && item_valid)
        begin
            prod_reg     <= {{RECIP_W{1'b0}}, item.mag} * {{ACC_W{1'b0}}, RECIP};
            prod_neg_reg <= item.neg;
            prod_end_reg <= item.frame_end;
        end
        if (out_load && prod_valid_reg)
        begin
            out_value_reg <= value_next;
            out_end_reg   <= prod_end_reg;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.filtered_value = out_value_reg;
    assign results.frame_end      = out_end_reg;

endmodule

FILE: src/integer_lowpass_filter.sv
// Top level of the integer lowpass filter for framed ECG samples.
//
//   channel   direction  payload                        transfer when
//   samples   in         sample_value[15:0] signed       valid && ready
//   results   out        filtered_value[15:0], frame_end valid && ready
//
// One sample is taken per cycle while samples.ready is high.
// The pace is set by the recursion register, which updates once per sample.
// The last sample of a frame is followed by M zero fill results, during
// which samples.ready is low; the filter state clears with that sample.
// A stall on results backs up the three result stages, then samples.ready.
// Reset clears the delay line, both past outputs and the sample index.
module integer_lowpass_filter
    import ilpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ilpf_in_if.sink    samples,
    ilpf_out_if.source results
);

    logic signed [SAMPLE_W-1:0] tap_q [DELAY_DEPTH];

    logic [ACC_W-1:0]   y1_reg;
    logic [ACC_W-1:0]   y1_next;
    logic [ACC_W-1:0]   y2_reg;
    logic [ACC_W-1:0]   y2_next;
    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    ilpf_item_t         s1_item_reg;
    ilpf_item_t         s1_item_next;

    logic               s1_load;
    logic               scale_ready;
    logic               accept;
    logic               last;
    logic               emit;
    logic [ACC_W-1:0]   x_ext;
    logic [ACC_W-1:0]   tap_mid;
    logic [ACC_W-1:0]   tap_end;
    logic [ACC_W-1:0]   acc;

    assign s1_load       = !s1_valid_reg || scale_ready;
    assign samples.ready = s1_load && (fill_reg == '0);
    assign accept        = samples.valid && samples.ready;
    assign last          = index_reg == INDEX_W'(FRAME_LEN - 1);
    assign emit          = index_reg >= INDEX_W'(TAP_SPACING);

    // Sign-extended operands of the recursion, all wrapping at 32 bits.
    assign x_ext   = {{(ACC_W-SAMPLE_W){samples.sample_value[SAMPLE_W-1]}},
                      samples.sample_value};
    assign tap_mid = {{(ACC_W-SAMPLE_W){tap_q[TAP_SPACING-1][SAMPLE_W-1]}},
                      tap_q[TAP_SPACING-1]};
    assign tap_end = {{(ACC_W-SAMPLE_W){tap_q[DELAY_DEPTH-1][SAMPLE_W-1]}},
                      tap_q[DELAY_DEPTH-1]};
    assign acc = {y1_reg[ACC_W-2:0], 1'b0} - y2_reg + x_ext
               - {tap_mid[ACC_W-2:0], 1'b0} + tap_end;

    genvar gi;
    generate
        for (gi = 0; gi < DELAY_DEPTH; gi++)
        begin : g_tap
            if (gi == 0)
            begin : g_head
                ilpf_tap u_tap (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (accept),
                    .clear (last),
                    .din   (samples.sample_value),
                    .dout  (tap_q[gi])
                );
            end
            else
            begin : g_body
                ilpf_tap u_tap (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (accept),
                    .clear (last),
                    .din   (tap_q[gi-1]),
                    .dout  (tap_q[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        y1_next       = y1_reg;
        y2_next       = y2_reg;
        index_next    = index_reg;
        fill_next     = fill_reg;
        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;

        if (s1_load)
        begin
            s1_valid_next = 1'b0;
            if (fill_reg != '0)
            begin
                // Zero fill goes through the scaler so that order is kept.
                s1_valid_next          = 1'b1;
                s1_item_next.mag       = '0;
                s1_item_next.neg       = 1'b0;
                s1_item_next.frame_end = fill_reg == FILL_W'(1);
                fill_next              = fill_reg - FILL_W'(1);
            end
            else if (accept)
            begin
                s1_valid_next          = emit;
                s1_item_next.neg       = acc[ACC_W-1];
                s1_item_next.mag       = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
                s1_item_next.frame_end = 1'b0;
                if (last)
                begin
                    y1_next    = '0;
                    y2_next    = '0;
                    index_next = '0;
                    fill_next  = FILL_W'(TAP_SPACING);
                end
                else
                begin
                    y1_next    = acc;
                    y2_next    = y1_reg;
                    index_next = index_reg + INDEX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_reg       <= '0;
            y2_reg       <= '0;
            index_reg    <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            y1_reg       <= y1_next;
            y2_reg       <= y2_next;
            index_reg    <= index_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
    end

    ilpf_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s1_valid_reg),
        .item       (s1_item_reg),
        .item_ready (scale_ready),
        .results    (results)
    );

endmodule

FILE: src/ilpf_checker.sv
// Port-level checks of the integer lowpass filter, bound to the top level.
module ilpf_checker
    import ilpf_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] out_value,
    input logic                       out_end
);

    // A held result must not change while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_end))
        else $error("stalled result changed");

    // The frame end mark only travels on a zero fill result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_end |-> out_value == '0)
        else $error("frame end on a nonzero result");

    // Two frame ends can never be transferred back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_end |=> !(out_valid && out_end))
        else $error("frame end repeated");

    // No result is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered in reset");

endmodule

bind integer_lowpass_filter ilpf_checker u_ilpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_value (results.filtered_value),
    .out_end   (results.frame_end)
);
